// ===== design/krt_pkg.sv =====
// keyed record table: shared types, widths and codes
// used by keyed_record_table; depends on nothing
package krt_pkg;

  localparam int KEY_W     = 16;
  localparam int SCORE_W   = 10;
  localparam int CNT_W     = 7;
  localparam int REC_W     = KEY_W + SCORE_W;
  localparam int DEPTH_DEF = 64;

  // operation codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_LIST   = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [KEY_W-1:0]   record_key;
    logic [SCORE_W-1:0] score_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   key_out;
    logic [SCORE_W-1:0] score_out;
    logic [CNT_W-1:0]   entry_count;
    logic               last;
  } rsp_t;

endpackage

// ===== design/keyed_record_table.sv =====
// keyed record table top level: sequencer, fill count and result register
// depends on krt_pkg and krt_ram
//
// Holds up to DEPTH records (16-bit key, 10-bit score in hundredths) in the
// order they were added, in one RAM with a single write port and a single
// registered read port. One request beat is taken at a time; req_stall is
// high from acceptance until the last result beat of that request has been
// loaded into the output register, which then waits on rsp_stall on its own.
// Add writes the new record in the dispatch state; search reads and compares
// one entry at a time up to and including the match; delete then moves each
// later record down one place with a read and a write; list reads, checks
// and emits one record at a time. Every compared or moved record costs one
// read through the registered RAM read port. Reset clears only the fill
// count and control state; the RAM contents are never read at or above the
// fill count, so it needs no clearing pass.
module keyed_record_table #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  krt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output krt_pkg::rsp_t rsp
);
  import krt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_LIST_RD  = 4'd6;
  localparam logic [3:0] S_LIST_CHK = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  logic [3:0]         state;
  logic [CNT_W-1:0]   count;
  logic [AW-1:0]      idx;
  req_t               cur;

  // pending result, loaded into the output register in S_EMIT
  logic [1:0]         res_status;
  logic [KEY_W-1:0]   res_key;
  logic [SCORE_W-1:0] res_score;
  logic               res_last;

  // ram ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [REC_W-1:0]   wr_data;
  logic [AW-1:0]      rd_addr;
  logic [REC_W-1:0]   rd_data;

  logic [KEY_W-1:0]   rd_key;
  logic [SCORE_W-1:0] rd_score;
  logic               at_end;
  logic               shift_done;
  logic               is_full;
  logic               out_load;

  assign rd_key   = rd_data[REC_W-1:SCORE_W];
  assign rd_score = rd_data[SCORE_W-1:0];

  // idx is the final occupied place / the final place to be overwritten
  assign at_end     = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign shift_done = (CNT_W'(idx) + CNT_W'(2)) == count;
  assign is_full    = count >= CNT_W'(DEPTH);

  assign req_stall = (state != S_IDLE);
  assign out_load  = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  // one read address: next-up record while shifting, else the walk pointer
  assign rd_addr = (state == S_SHIFT_RD) ? (idx + AW'(1)) : idx;

  // writes: append on add, move down one place while shifting
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (state == S_DISPATCH && cur.kind == KIND_ADD && !is_full) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = {cur.record_key, cur.score_in};
    end else if (state == S_SHIFT_WR) begin
      wr_en = 1'b1;
    end
  end

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            idx   <= '0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_key   <= '0;
          res_score <= '0;
          res_last  <= 1'b1;
          res_status <= ST_OK;
          case (cur.kind)
            KIND_ADD: begin
              if (is_full) begin
                res_status <= ST_FULL;
              end else begin
                count <= count + CNT_W'(1);
              end
              state <= S_EMIT;
            end
            KIND_LIST: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_EMIT;
              end else begin
                state <= S_LIST_RD;
              end
            end
            default: begin
              // search and delete both start with a scan
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_EMIT;
              end else begin
                state <= S_SCAN_RD;
              end
            end
          endcase
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rd_key == cur.record_key) begin
            res_key   <= rd_key;
            res_score <= rd_score;
            if (cur.kind == KIND_DELETE && !at_end) begin
              state <= S_SHIFT_RD;
            end else begin
              if (cur.kind == KIND_DELETE) begin
                count <= count - CNT_W'(1);
              end
              state <= S_EMIT;
            end
          end else if (at_end) begin
            res_status <= ST_MISSING;
            state      <= S_EMIT;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (shift_done) begin
            count <= count - CNT_W'(1);
            state <= S_EMIT;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SHIFT_RD;
          end
        end
        S_LIST_RD: begin
          state <= S_LIST_CHK;
        end
        S_LIST_CHK: begin
          res_status <= ST_OK;
          res_key    <= rd_key;
          res_score  <= rd_score;
          res_last   <= at_end;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_LIST_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: holds a beat until the far side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status      <= res_status;
      rsp.key_out     <= res_key;
      rsp.score_out   <= res_score;
      rsp.entry_count <= count;
      rsp.last        <= res_last;
    end
  end

`ifndef SYNTHESIS
  // the fill count moves by at most one record per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
    (count == $past(count) - CNT_W'(1)))
    else $error("fill count jumped");

  // the fill count only changes where an add or a delete completes
  a_count_where: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (($past(state) == S_DISPATCH) || ($past(state) == S_SCAN_CHK) ||
       ($past(state) == S_SHIFT_WR)))
    else $error("fill count changed outside add or delete");

  // an accepted beat always starts the sequencer
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DISPATCH))
    else $error("accepted request not dispatched");

  // only list beats can be non-final, and they always carry a record
  a_mid_list_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.status == ST_OK))
    else $error("non-final result without a record");

  // the table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entry_count <= CNT_W'(DEPTH)))
    else $error("entry count beyond depth");
`endif

endmodule

// ===== design/krt_ram.sv =====
// generic single-write, single-read RAM with registered read data
// stand-alone; no package needed
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
